// ===== hdl/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	localparam int CAP_BITS   = 5;
	localparam int CAP_RESET  = 16;
	localparam int FIELD_BITS = 32;

	localparam logic [FIELD_BITS-1:0] MISS_VALUE = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [FIELD_BITS-1:0] key;
		logic [FIELD_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic                  evicted;
		logic [FIELD_BITS-1:0] read_value;
	} res_t;

endpackage

// ===== hdl/lkv_core.sv =====
`timescale 1ns / 1ps

module lkv_core import lkv_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  req_t                req,
	input  logic [CAP_BITS-1:0] capacity,
	output res_t                res
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

	logic [KEY_BITS-1:0]   key_q [ENTRIES];
	logic [VALUE_BITS-1:0] val_q [ENTRIES];
	logic [IDX_W-1:0]      age_q [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [CNT_W-1:0]      fill_q;

	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] val_in;
	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    lru_vec;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      lru_idx;
	logic [IDX_W-1:0]      tgt_idx;
	logic [CNT_W-1:0]      rank;
	logic [CNT_W-1:0]      last_rank;
	logic [CMP_W-1:0]      cap_eff;
	logic                  hit_any;
	logic                  is_put;
	logic                  room;
	logic                  do_fill;
	logic                  do_evict;
	logic                  do_touch;

	assign key_in    = KEY_BITS'(req.key);
	assign val_in    = VALUE_BITS'(req.value);
	assign is_put    = (req.op == OP_PUT);
	assign last_rank = fill_q - CNT_W'(1);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (key_q[i] == key_in);
			// Ranks are a permutation of 0..fill-1, so exactly one lane holds the oldest.
			lru_vec[i]   = valid_q[i] && (CNT_W'(age_q[i]) == last_rank);
		end
	end

	// Lowest-numbered lane wins in each search.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		lru_idx  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			if (lru_vec[i]) begin
				lru_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		cap_eff = CMP_W'(capacity);
		if (cap_eff == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_eff > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end
	end

	assign hit_any  = |match_vec;
	assign room     = CMP_W'(fill_q) < cap_eff;
	assign do_fill  = is_put && !hit_any && room;
	assign do_evict = is_put && !hit_any && !room;
	assign do_touch = hit_any || is_put;

	always_comb begin
		if (hit_any) begin
			tgt_idx = hit_idx;
		end else if (do_fill) begin
			tgt_idx = free_idx;
		end else begin
			tgt_idx = lru_idx;
		end
	end

	// A fresh or evicting put ages every other valid entry; a hit ages only the younger ones.
	assign rank = hit_any ? CNT_W'(age_q[hit_idx]) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (step && do_touch) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == tgt_idx) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && (CNT_W'(age_q[i]) < rank)) begin
					age_q[i] <= age_q[i] + IDX_W'(1);
				end
			end
			if (do_fill) begin
				valid_q[tgt_idx] <= 1'b1;
				fill_q           <= fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_put) begin
			val_q[tgt_idx] <= val_in;
			if (!hit_any) begin
				key_q[tgt_idx] <= key_in;
			end
		end
	end

	always_comb begin
		res.hit        = hit_any;
		res.evicted    = do_evict;
		res.read_value = MISS_VALUE;
		if (hit_any && !is_put) begin
			res.read_value = FIELD_BITS'(signed'(val_q[hit_idx]));
		end
	end

`ifndef SYNTH
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("fill count disagrees with valid entries");

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("key present in more than one entry");

	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> $onehot(lru_vec))
		else $error("recency ranks are not a permutation");

	a_evict_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step && do_evict) |=> $stable(fill_q))
		else $error("eviction changed the fill count");

	a_evict_needs_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(step && do_evict) |-> (fill_q != '0))
		else $error("eviction with an empty store");
`endif

endmodule

// ===== hdl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        tuser: op; tdata: lookup_key, write_value
// m_*       out        m_tvalid / m_tready        tuser: hit, evicted; tdata: read_value
// cfg_*     in         cfg_valid / cfg_ready      cfg_data: capacity
//
// An accepted item passes through the request register, then through the parallel key
// compare and rank update into the result register. One item per cycle is sustained
// while m_tready stays high; the store is read and updated in that single stage.
// Reset clears the valid bits, ranks and fill count at once and sets capacity to 16.
// A stalled result holds the result register; one more item may wait in the request register.

module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [2*FIELD_BITS-1:0] s_tdata,  // lookup_key, write_value
	input  logic                    s_tuser,  // op
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [FIELD_BITS-1:0]   m_tdata,  // read_value
	output logic [1:0]              m_tuser,  // hit, evicted
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CAP_BITS-1:0]     cfg_data
);

	req_t                req_s1;
	logic                valid_s1;
	res_t                res_q;
	logic                m_valid_q;
	logic [CAP_BITS-1:0] capacity_q;
	res_t                res_next;
	logic                out_free;
	logic                step;

	assign out_free  = !m_valid_q || m_tready;
	assign step      = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_BITS'(CAP_RESET);
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.op    <= op_t'(s_tuser);
			req_s1.key   <= s_tdata[FIELD_BITS-1:0];
			req_s1.value <= s_tdata[2*FIELD_BITS-1:FIELD_BITS];
		end
		if (step) begin
			res_q <= res_next;
		end
	end

	lkv_core #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req      (req_s1),
		.capacity (capacity_q),
		.res      (res_next)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q.read_value;
	assign m_tuser  = {res_q.evicted, res_q.hit};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lkv_pkg::*;

	localparam int ENTRIES     = DEF_ENTRIES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 120;
	localparam int HOLD_LEN    = 80;
	localparam int PHASE_ITEMS = 75;

	// Tracks the cache contents and recency ranks, and holds the replies still owed.
	class lru_tracker;
		logic [FIELD_BITS-1:0] keys[ENTRIES];
		logic [FIELD_BITS-1:0] vals[ENTRIES];
		bit                    valid[ENTRIES];
		int unsigned           rank[ENTRIES];
		int unsigned           fill;
		logic [CAP_BITS-1:0]   capacity = CAP_RESET;
		res_t                  pending_replies[$];
		int                    errors;

		// Moves one entry to rank zero; only entries younger than old_rank age.
		function void promote(int idx, int unsigned old_rank);
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i] && i != idx && rank[i] < old_rank)
					rank[i]++;
			rank[idx] = 0;
		endfunction

		function void note_request(op_t op, logic [FIELD_BITS-1:0] key,
				logic [FIELD_BITS-1:0] val);
			res_t        r;
			int          found;
			int          slot;
			int          lru;
			int unsigned lim;
			found = -1;
			slot  = -1;
			lru   = -1;
			lim   = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
			r.hit        = 1'b0;
			r.evicted    = 1'b0;
			r.read_value = MISS_VALUE;
			for (int i = 0; i < ENTRIES; i++)
				if (found < 0 && valid[i] && keys[i] == key)
					found = i;
			if (found >= 0) begin
				r.hit = 1'b1;
				if (op == OP_PUT)
					vals[found] = val;
				else
					r.read_value = vals[found];
				promote(found, rank[found]);
			end else if (op == OP_PUT) begin
				if (fill < lim)
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !valid[i])
							slot = i;
				if (slot >= 0) begin
					promote(slot, fill);
					valid[slot] = 1'b1;
					keys[slot]  = key;
					vals[slot]  = val;
					fill++;
				end else begin
					// The lowest-numbered entry with the oldest rank is replaced.
					for (int i = 0; i < ENTRIES; i++)
						if (valid[i] && (lru < 0 || rank[i] > rank[lru]))
							lru = i;
					keys[lru] = key;
					vals[lru] = val;
					promote(lru, rank[lru]);
					r.evicted = 1'b1;
				end
			end
			pending_replies.push_back(r);
		endfunction

		function void check_reply(logic hit, logic evicted, logic [FIELD_BITS-1:0] read_value);
			res_t e;
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: hit %0d evicted %0d read_value %h",
					hit, evicted, read_value);
				errors++;
				return;
			end
			e = pending_replies.pop_front();
			if (hit !== e.hit) begin
				$error("hit: expected %0d, actual %0d", e.hit, hit);
				errors++;
			end
			if (evicted !== e.evicted) begin
				$error("evicted: expected %0d, actual %0d", e.evicted, evicted);
				errors++;
			end
			if (read_value !== e.read_value) begin
				$error("read_value: expected %h, actual %h", e.read_value, read_value);
				errors++;
			end
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [2*FIELD_BITS-1:0] s_tdata   = '0;  // lookup_key, write_value
	logic                    s_tuser   = 1'b0;  // op
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [FIELD_BITS-1:0]   m_tdata;  // read_value
	logic [1:0]              m_tuser;  // hit, evicted
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CAP_BITS-1:0]     cfg_data  = '0;

	lru_tracker tracker = new;

	int tx_idle_pct = 13;
	int rx_idle_pct = 62;
	int replies_seen;
	int hold_left;
	bit hold_done;
	int cycles;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL lru_key_value_cache");
			$finish;
		end
	end

	// Reply side: checks every accepted item and stalls at random. Once, it also
	// holds off for a long stretch so that the block backs up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				tracker.check_reply(m_tuser[0], m_tuser[1], m_tdata);
				replies_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (replies_seen == HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Leaves s_tvalid high after acceptance unless a gap is drawn, so a following
	// call in the same step only raises it again.
	task automatic send_item(op_t op, logic [FIELD_BITS-1:0] key, logic [FIELD_BITS-1:0] val);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {val, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_request(op, key, val);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_BITS-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tracker.capacity = value;
	endtask

	task automatic random_phase(int items, logic [CAP_BITS-1:0] cap);
		logic [FIELD_BITS-1:0] pool[$];
		logic [FIELD_BITS-1:0] key;
		int                    eff;
		op_t                   op;
		eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
		// A pool slightly larger than the capacity gives hits and evictions alike.
		repeat (eff + $urandom_range(1, 3))
			pool.push_back($urandom());
		repeat (items) begin
			op  = $urandom_range(1) ? OP_PUT : OP_GET;
			key = ($urandom_range(99) < 85) ? pool[$urandom_range(pool.size() - 1)]
				: $urandom();
			send_item(op, key, $urandom());
		end
	endtask

	initial begin
		logic [CAP_BITS-1:0] caps[8];
		caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd2, 5'd17, 5'd9};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of keys and values, updates, and a repeated touch of the newest entry.
		send_item(OP_GET, 32'h0000_0000, 32'h5555_5555);
		send_item(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_item(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_item(OP_GET, 32'h8000_0000, 32'hffff_ffff);
		send_item(OP_GET, 32'hffff_ffff, 32'h0000_0000);
		send_item(OP_PUT, 32'h0000_0000, 32'h1234_5678);
		send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);

		// Capacity dropped below the fill count: each new key evicts.
		write_capacity(5'd2);
		send_item(OP_PUT, 32'h0000_0011, 32'haaaa_aaaa);
		send_item(OP_PUT, 32'h0000_0022, 32'h5555_5555);
		send_item(OP_PUT, 32'h0000_0033, 32'hdead_beef);
		send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_item(OP_GET, 32'h0000_0033, 32'h0000_0000);

		// A capacity of zero behaves as one.
		write_capacity(5'd0);
		send_item(OP_PUT, 32'h0000_0044, 32'h0bad_cafe);
		send_item(OP_GET, 32'h0000_0033, 32'h0000_0000);
		send_item(OP_PUT, 32'h0000_0044, 32'hcafe_0bad);
		send_item(OP_GET, 32'h0000_0044, 32'h0000_0000);

		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			if (p == 3) begin
				tx_idle_pct = 62;
				rx_idle_pct = 13;
			end else if (p == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			random_phase(PHASE_ITEMS, caps[p]);
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_replies.size() == 0)
			$display("PASS lru_key_value_cache");
		else
			$display("FAIL lru_key_value_cache");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lkv_pkg.sv
hdl/lkv_core.sv
hdl/lru_key_value_cache.sv
verif/testbench.sv
